// File: hdl/sui_pkg.sv
// ----------------------------------------------------------------------------
// sui_pkg
// shared types and codes for the set union / intersection block
// ----------------------------------------------------------------------------
`default_nettype none

package sui_pkg;

  localparam int ELEM_W = 16;
  localparam int OP_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR         = 3'd0,
    OP_APPEND_FIRST  = 3'd1,
    OP_APPEND_SECOND = 3'd2,
    OP_UNION         = 3'd3,
    OP_INTERSECT     = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ELEM_W-1:0] element;
  } cmd_t;

  typedef struct packed {
    logic [ELEM_W-1:0] member;
    logic              last_member;
    logic              empty_set;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/sui_fifo.sv
// ----------------------------------------------------------------------------
// sui_fifo
// small synchronous first-in first-out queue of words
// ----------------------------------------------------------------------------
`default_nettype none

module sui_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/sui_front.sv
// ----------------------------------------------------------------------------
// sui_front
// accepts input words, classifies the operation and queues known commands
// ----------------------------------------------------------------------------
`default_nettype none

module sui_front (
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [sui_pkg::OP_W-1:0]      operation,
  input  wire logic [sui_pkg::ELEM_W-1:0]    element,
  output logic                               cmd_push,
  output sui_pkg::cmd_t                      cmd,
  input  wire logic                          cmd_full
);

  import sui_pkg::*;

  logic known;

  always_comb begin
    unique case (operation)
      OP_CLEAR, OP_APPEND_FIRST, OP_APPEND_SECOND, OP_UNION, OP_INTERSECT: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // unused codes are taken and dropped here
  assign full        = cmd_full;
  assign cmd_push    = push && !cmd_full && known;
  assign cmd.op      = op_t'(operation);
  assign cmd.element = element;

endmodule

`default_nettype wire

// File: hdl/sui_back.sv
// ----------------------------------------------------------------------------
// sui_back
// holds both sets and walks them to build union and intersection reports
// ----------------------------------------------------------------------------
`default_nettype none

module sui_back #(
  parameter int SET_CAPACITY = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sui_pkg::cmd_t  cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output logic                res_push,
  output sui_pkg::result_t    res,
  input  wire logic           res_full
);

  import sui_pkg::*;

  localparam int CNT_W = $clog2(SET_CAPACITY + 1);
  localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_TEST = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    PH_UNION_FIRST  = 3'b001,
    PH_UNION_SECOND = 3'b010,
    PH_INTER        = 3'b100
  } phase_t;

  logic [ELEM_W-1:0] first_store  [SET_CAPACITY];
  logic [ELEM_W-1:0] second_store [SET_CAPACITY];

  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  first_count, first_count_next;
  logic [CNT_W-1:0]  second_count, second_count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [ELEM_W-1:0] cand, cand_next;
  logic [ELEM_W-1:0] pend, pend_next;
  logic              pend_valid, pend_valid_next;

  logic              wr_first;
  logic              wr_second;
  logic [CNT_W-1:0]  outer_count;
  logic [ELEM_W-1:0] outer_elem;
  logic [CNT_W-1:0]  other_count;
  logic              hit;
  logic              keep;

  always_comb begin
    outer_count = (phase == PH_UNION_SECOND) ? second_count : first_count;
    outer_elem  = (phase == PH_UNION_SECOND) ? second_store[idx[IDX_W-1:0]]
                                             : first_store[idx[IDX_W-1:0]];
    other_count = (phase == PH_INTER) ? second_count : first_count;
  end

  // candidate against every live entry of the other set
  always_comb begin
    logic [ELEM_W-1:0] other_val;
    hit = 1'b0;
    for (int j = 0; j < SET_CAPACITY; j++) begin
      other_val = (phase == PH_INTER) ? second_store[j] : first_store[j];
      if ((CNT_W'(j) < other_count) && (other_val == cand)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (phase)
      PH_UNION_FIRST:  keep = 1'b1;
      PH_UNION_SECOND: keep = !hit;
      PH_INTER:        keep = hit;
      default:         keep = 1'b0;
    endcase
  end

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    first_count_next  = first_count;
    second_count_next = second_count;
    idx_next          = idx;
    cand_next         = cand;
    pend_next         = pend;
    pend_valid_next   = pend_valid;
    wr_first          = 1'b0;
    wr_second         = 1'b0;
    cmd_pop           = 1'b0;
    res_push          = 1'b0;
    res               = '0;

    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_CLEAR: begin
              first_count_next  = '0;
              second_count_next = '0;
            end
            OP_APPEND_FIRST: begin
              if (first_count < CNT_W'(SET_CAPACITY)) begin
                wr_first         = 1'b1;
                first_count_next = first_count + CNT_W'(1);
              end
            end
            OP_APPEND_SECOND: begin
              if (second_count < CNT_W'(SET_CAPACITY)) begin
                wr_second         = 1'b1;
                second_count_next = second_count + CNT_W'(1);
              end
            end
            OP_UNION: begin
              phase_next      = PH_UNION_FIRST;
              idx_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = ST_SCAN;
            end
            OP_INTERSECT: begin
              phase_next      = PH_INTER;
              idx_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (idx < outer_count) begin
          cand_next  = outer_elem;
          state_next = ST_TEST;
        end else if (phase == PH_UNION_FIRST) begin
          phase_next = PH_UNION_SECOND;
          idx_next   = '0;
        end else if (!res_full) begin
          res_push        = 1'b1;
          res.member      = pend_valid ? pend : '0;
          res.last_member = 1'b1;
          res.empty_set   = !pend_valid;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      ST_TEST: begin
        if (keep && pend_valid) begin
          if (!res_full) begin
            res_push   = 1'b1;
            res.member = pend;
            pend_next  = cand;
            idx_next   = idx + CNT_W'(1);
            state_next = ST_SCAN;
          end
        end else begin
          if (keep) begin
            pend_next       = cand;
            pend_valid_next = 1'b1;
          end
          idx_next   = idx + CNT_W'(1);
          state_next = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_store[first_count[IDX_W-1:0]] <= cmd.element;
    end
    if (wr_second) begin
      second_store[second_count[IDX_W-1:0]] <= cmd.element;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_UNION_FIRST;
      first_count  <= '0;
      second_count <= '0;
      idx          <= '0;
      pend_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
      idx          <= idx_next;
      pend_valid   <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cand <= cand_next;
    pend <= pend_next;
  end

endmodule

`default_nettype wire

// File: hdl/set_union_intersection.sv
// ----------------------------------------------------------------------------
// set_union_intersection
// Two ordered sets of 16-bit elements with union and intersection reports.
// Commands enter a four-word queue and are executed in order by the back
// end, which takes no new command while a report runs. A report walks the
// outer set one element at a time, each step comparing the element against
// every live entry of the other set at once, and stalls while the result
// queue is full. Each report ends with last_member set; an empty report is a
// single word with empty_set and last_member set and member zero. Appends to
// a full set and unused operation codes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module set_union_intersection #(
  parameter int SET_CAPACITY = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [sui_pkg::OP_W-1:0]   operation,
  input  wire logic [sui_pkg::ELEM_W-1:0] element,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [sui_pkg::ELEM_W-1:0]      member,
  output logic                            last_member,
  output logic                            empty_set
);

  import sui_pkg::*;

  cmd_t    front_cmd;
  cmd_t    back_cmd;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res_in;
  result_t res_out;
  logic    res_push;
  logic    res_full;

  sui_front u_front (
    .push      (push),
    .full      (full),
    .operation (operation),
    .element   (element),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd),
    .cmd_full  (cmd_full)
  );

  sui_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (4)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (back_cmd),
    .empty   (cmd_empty)
  );

  sui_back #(
    .SET_CAPACITY (SET_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  sui_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign member      = res_out.member;
  assign last_member = res_out.last_member;
  assign empty_set   = res_out.empty_set;

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result word written into a full queue");

  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty queue");

  a_empty_word_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_set) |-> (last_member && (member == '0)))
    else $error("empty report word is malformed");

endmodule

`default_nettype wire
